FILE: sv/rtsm_pkg.sv
// package: shared types, codes and default sizes of the rule table state machine
package rtsm_pkg;

    localparam int DEF_STATE_SLOTS = 8;
    localparam int DEF_EVENT_SLOTS = 32;
    localparam int DEF_RULE_SLOTS  = 128;
    localparam int DEF_ID_BITS     = 8;

    typedef enum logic [2:0] {
        REQ_ADD_STATE = 3'd0,
        REQ_ADD_EVENT = 3'd1,
        REQ_ADD_RULE  = 3'd2,
        REQ_START     = 3'd3,
        REQ_TRIGGER   = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FAIL     = 3'd1,
        ST_FULL     = 3'd2,
        ST_EXISTS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        SC_EV_EID,
        SC_ST_SID,
        SC_ST_FROM,
        SC_ST_TO,
        SC_ST_RTO,
        SC_ST_CUR,
        SC_RULE_ADD,
        SC_RULE_EXACT,
        SC_RULE_WILD
    } t_scan;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SSID,
        S_EV,
        S_FROM,
        S_TO,
        S_RDUP,
        S_REX,
        S_RWD,
        S_NEW,
        S_OLD,
        S_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [7:0]        state_id;
        logic [7:0]        event_id;
        logic signed [15:0] handler_code;
        logic              from_is_wildcard;
        logic [7:0]        from_state;
        logic              to_is_wildcard;
        logic [7:0]        to_state;
        logic              has_enter_action;
        logic              has_exit_action;
    } t_in;

    typedef struct packed {
        logic [2:0] status_code;
        logic       moved;
        logic       run_exit;
        logic [7:0] left_state;
        logic       run_enter;
        logic [7:0] current_out;
        logic       started;
    } t_out;

    typedef struct packed {
        logic    accept;
        logic    scan_go;
        t_scan   scan_sel;
        logic    wr_state;
        logic    wr_event;
        logic    wr_rule;
        logic    do_start;
        logic    do_move;
        logic    finish;
        t_status status;
        logic    moved;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       from_wild;
        logic       to_wild;
        logic       sid_zero;
        logic       eid_zero;
        logic       st_full;
        logic       ev_full;
        logic       rule_full;
        logic       scan_done;
        logic       scan_found;
        logic       need_move;
        logic       cur_concrete;
        logic       out_busy;
    } t_stat;

endpackage

FILE: sv/rtsm_ram.sv
// generic single write port ram with registered read
module rtsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/rtsm_ctrl.sv
// controller: request sequencing state machine
module rtsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtsm_pkg::t_stat i_stat,
    output rtsm_pkg::t_cmd  o_cmd
);
    import rtsm_pkg::*;

    t_ctrl_state r_state, n_state;
    t_status     r_status, n_status;
    logic        r_moved, n_moved;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_moved  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_moved  <= n_moved;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_moved  = r_moved;
        cmd      = '0;
        cmd.scan_sel = SC_EV_EID;
        cmd.status   = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                n_moved = 1'b0;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (t_req'(i_stat.req_type))
                    REQ_ADD_STATE: begin
                        if (i_stat.sid_zero) begin
                            n_status = ST_FAIL; n_state = S_DONE;
                        end else if (i_stat.st_full) begin
                            n_status = ST_FULL; n_state = S_DONE;
                        end else begin
                            cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_SID; n_state = S_SSID;
                        end
                    end
                    REQ_ADD_EVENT: begin
                        if (i_stat.eid_zero) begin
                            n_status = ST_FAIL; n_state = S_DONE;
                        end else if (i_stat.ev_full) begin
                            n_status = ST_FULL; n_state = S_DONE;
                        end else begin
                            cmd.scan_go = 1'b1; cmd.scan_sel = SC_EV_EID; n_state = S_EV;
                        end
                    end
                    REQ_ADD_RULE: begin
                        if (i_stat.rule_full) begin
                            n_status = ST_FULL; n_state = S_DONE;
                        end else begin
                            cmd.scan_go = 1'b1; cmd.scan_sel = SC_EV_EID; n_state = S_EV;
                        end
                    end
                    REQ_START: begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_SID; n_state = S_SSID;
                    end
                    REQ_TRIGGER: begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_EV_EID; n_state = S_EV;
                    end
                    default: begin
                        n_status = ST_FAIL; n_state = S_DONE;
                    end
                endcase
            end
            S_SSID: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                    if (t_req'(i_stat.req_type) == REQ_ADD_STATE) begin
                        if (i_stat.scan_found) begin
                            n_status = ST_EXISTS;
                        end else begin
                            cmd.wr_state = 1'b1; n_status = ST_OK;
                        end
                    end else if (i_stat.scan_found) begin
                        cmd.do_start = 1'b1; n_status = ST_OK;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
            end
            S_EV: begin
                if (i_stat.scan_done) begin
                    if (t_req'(i_stat.req_type) == REQ_ADD_EVENT) begin
                        n_state = S_DONE;
                        if (i_stat.scan_found) begin
                            n_status = ST_EXISTS;
                        end else begin
                            cmd.wr_event = 1'b1; n_status = ST_OK;
                        end
                    end else if (!i_stat.scan_found) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end else if (t_req'(i_stat.req_type) == REQ_TRIGGER) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_RULE_EXACT; n_state = S_REX;
                    end else if (!i_stat.from_wild) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_FROM; n_state = S_FROM;
                    end else if (!i_stat.to_wild) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_TO; n_state = S_TO;
                    end else begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_RULE_ADD; n_state = S_RDUP;
                    end
                end
            end
            S_FROM: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end else if (!i_stat.to_wild) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_TO; n_state = S_TO;
                    end else begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_RULE_ADD; n_state = S_RDUP;
                    end
                end
            end
            S_TO: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end else begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_RULE_ADD; n_state = S_RDUP;
                    end
                end
            end
            S_RDUP: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                    if (i_stat.scan_found) begin
                        n_status = ST_EXISTS;
                    end else begin
                        cmd.wr_rule = 1'b1; n_status = ST_OK;
                    end
                end
            end
            S_REX, S_RWD: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_found) begin
                        n_status = ST_OK;
                        if (i_stat.need_move) begin
                            cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_RTO; n_state = S_NEW;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (r_state == S_REX && i_stat.cur_concrete) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_RULE_WILD; n_state = S_RWD;
                    end else begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end
                end
            end
            S_NEW: begin
                if (i_stat.scan_done) begin
                    if (i_stat.cur_concrete) begin
                        cmd.scan_go = 1'b1; cmd.scan_sel = SC_ST_CUR; n_state = S_OLD;
                    end else begin
                        cmd.do_move = 1'b1; n_moved = 1'b1; n_state = S_DONE;
                    end
                end
            end
            S_OLD: begin
                if (i_stat.scan_done) begin
                    cmd.do_move = 1'b1; n_moved = 1'b1; n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    cmd.finish = 1'b1;
                    cmd.status = r_status;
                    cmd.moved  = r_moved;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule

FILE: sv/rtsm_dp.sv
// datapath: stores, scan engine, current state and result register
module rtsm_dp #(
    parameter int STATE_SLOTS = rtsm_pkg::DEF_STATE_SLOTS,
    parameter int EVENT_SLOTS = rtsm_pkg::DEF_EVENT_SLOTS,
    parameter int RULE_SLOTS  = rtsm_pkg::DEF_RULE_SLOTS,
    parameter int ID_BITS     = rtsm_pkg::DEF_ID_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rtsm_pkg::t_in  i_in_data,
    input  rtsm_pkg::t_cmd i_cmd,
    output rtsm_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rtsm_pkg::t_out o_out_data
);
    import rtsm_pkg::*;

    localparam int CB   = (ID_BITS < 8) ? ID_BITS : 8;
    localparam int SUW  = $clog2(STATE_SLOTS + 1);
    localparam int EUW  = $clog2(EVENT_SLOTS + 1);
    localparam int RUW  = $clog2(RULE_SLOTS + 1);
    localparam int IW   = (SUW > EUW) ? ((SUW > RUW) ? SUW : RUW) : ((EUW > RUW) ? EUW : RUW);
    localparam int SAW  = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
    localparam int EAW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int RAW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int SW   = ID_BITS + 2;
    localparam int RW   = 3 * ID_BITS + 18;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               enter;
        logic               leave;
    } t_srec;

    typedef struct packed {
        logic               fw;
        logic [ID_BITS-1:0] from;
        logic [ID_BITS-1:0] ev;
        logic [15:0]        code;
        logic               tw;
        logic [ID_BITS-1:0] to;
    } t_rrec;

    function automatic logic [ID_BITS-1:0] f_id(input logic [7:0] x);
        return ID_BITS'(x[CB-1:0]);
    endfunction

    t_in                r_req;
    logic [ID_BITS-1:0] r_cur;
    logic               r_cc;
    logic [SUW-1:0]     r_st_used;
    logic [EUW-1:0]     r_ev_used;
    logic [RUW-1:0]     r_ru_used;
    logic               r_scan_act, r_cmp_v, r_done, r_found;
    logic [IW-1:0]      r_idx;
    t_scan              r_sel;
    logic               r_rtw;
    logic [ID_BITS-1:0] r_rto;
    logic               r_enter, r_exit;
    logic [ID_BITS-1:0] r_left;
    logic               r_out_valid;
    t_out               r_out;

    logic [ID_BITS-1:0] sid, eid, fs, ts;
    logic [SW-1:0]      st_rdata;
    logic [ID_BITS-1:0] ev_rdata;
    logic [RW-1:0]      ru_rdata;
    t_srec              srec, s_wr;
    t_rrec              rrec, r_wr;
    logic               hit;
    logic [IW-1:0]      count;

    assign sid  = f_id(r_req.state_id);
    assign eid  = f_id(r_req.event_id);
    assign fs   = f_id(r_req.from_state);
    assign ts   = f_id(r_req.to_state);
    assign srec = t_srec'(st_rdata);
    assign rrec = t_rrec'(ru_rdata);

    always_comb begin
        s_wr.id    = sid;
        s_wr.enter = r_req.has_enter_action;
        s_wr.leave = r_req.has_exit_action;
        r_wr.fw    = r_req.from_is_wildcard;
        r_wr.from  = r_req.from_is_wildcard ? '0 : fs;
        r_wr.ev    = eid;
        r_wr.code  = r_req.handler_code;
        r_wr.tw    = r_req.to_is_wildcard;
        r_wr.to    = r_req.to_is_wildcard ? '0 : ts;
    end

    rtsm_ram #(.WIDTH(SW), .DEPTH(STATE_SLOTS)) u_st_ram (
        .i_clk(i_clk), .i_we(i_cmd.wr_state), .i_waddr(r_st_used[SAW-1:0]),
        .i_wdata(s_wr), .i_raddr(r_idx[SAW-1:0]), .o_rdata(st_rdata)
    );
    rtsm_ram #(.WIDTH(ID_BITS), .DEPTH(EVENT_SLOTS)) u_ev_ram (
        .i_clk(i_clk), .i_we(i_cmd.wr_event), .i_waddr(r_ev_used[EAW-1:0]),
        .i_wdata(eid), .i_raddr(r_idx[EAW-1:0]), .o_rdata(ev_rdata)
    );
    rtsm_ram #(.WIDTH(RW), .DEPTH(RULE_SLOTS)) u_ru_ram (
        .i_clk(i_clk), .i_we(i_cmd.wr_rule), .i_waddr(r_ru_used[RAW-1:0]),
        .i_wdata(r_wr), .i_raddr(r_idx[RAW-1:0]), .o_rdata(ru_rdata)
    );

    always_comb begin
        unique case (r_sel)
            SC_EV_EID: begin
                count = IW'(r_ev_used);
                hit   = (ev_rdata == eid);
            end
            SC_ST_SID: begin
                count = IW'(r_st_used);
                hit   = (srec.id == sid);
            end
            SC_ST_FROM: begin
                count = IW'(r_st_used);
                hit   = (srec.id == fs);
            end
            SC_ST_TO: begin
                count = IW'(r_st_used);
                hit   = (srec.id == ts);
            end
            SC_ST_RTO: begin
                count = IW'(r_st_used);
                hit   = (srec.id == r_rto);
            end
            SC_ST_CUR: begin
                count = IW'(r_st_used);
                hit   = (srec.id == r_cur);
            end
            SC_RULE_ADD: begin
                count = IW'(r_ru_used);
                hit   = (rrec.fw == r_req.from_is_wildcard) && (rrec.ev == eid)
                     && (rrec.code == r_req.handler_code)
                     && (r_req.from_is_wildcard || rrec.from == fs);
            end
            SC_RULE_EXACT: begin
                count = IW'(r_ru_used);
                hit   = (rrec.fw == !r_cc) && (rrec.ev == eid)
                     && (rrec.code == r_req.handler_code) && (!r_cc || rrec.from == r_cur);
            end
            SC_RULE_WILD: begin
                count = IW'(r_ru_used);
                hit   = rrec.fw && (rrec.ev == eid) && (rrec.code == r_req.handler_code);
            end
            default: begin
                count = '0;
                hit   = 1'b0;
            end
        endcase
        hit = hit && r_cmp_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_cc        <= 1'b0;
            r_st_used   <= '0;
            r_ev_used   <= '0;
            r_ru_used   <= '0;
            r_scan_act  <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_sel       <= SC_EV_EID;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.scan_go) begin
                r_scan_act <= 1'b1;
                r_cmp_v    <= 1'b0;
                r_idx      <= '0;
                r_sel      <= i_cmd.scan_sel;
            end else if (r_scan_act) begin
                if (hit) begin
                    r_scan_act <= 1'b0;
                    r_cmp_v    <= 1'b0;
                    r_done     <= 1'b1;
                    r_found    <= 1'b1;
                end else if (r_idx < count) begin
                    r_idx   <= r_idx + 1'b1;
                    r_cmp_v <= 1'b1;
                end else if (!r_cmp_v) begin
                    r_scan_act <= 1'b0;
                    r_done     <= 1'b1;
                    r_found    <= 1'b0;
                end else begin
                    r_cmp_v <= 1'b0;
                end
            end
            if (i_cmd.wr_state) r_st_used <= r_st_used + 1'b1;
            if (i_cmd.wr_event) r_ev_used <= r_ev_used + 1'b1;
            if (i_cmd.wr_rule)  r_ru_used <= r_ru_used + 1'b1;
            if (i_cmd.do_start) begin
                r_cur <= sid;
                r_cc  <= 1'b1;
            end else if (i_cmd.do_move) begin
                r_cur <= r_rto;
                r_cc  <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_in_data;
            r_enter <= 1'b0;
            r_exit  <= 1'b0;
        end
        if (r_scan_act && !i_cmd.scan_go && hit) begin
            if (r_sel == SC_RULE_EXACT || r_sel == SC_RULE_WILD) begin
                r_rtw <= rrec.tw;
                r_rto <= rrec.to;
            end
            if (r_sel == SC_ST_RTO) r_enter <= srec.enter;
            if (r_sel == SC_ST_CUR) r_exit  <= srec.leave;
        end
        if (i_cmd.do_move) begin
            r_left <= r_cc ? r_cur : '0;
        end
        if (i_cmd.finish) begin
            r_out.status_code <= i_cmd.status;
            r_out.moved       <= i_cmd.moved;
            r_out.run_exit    <= i_cmd.moved & r_exit;
            r_out.left_state  <= i_cmd.moved ? 8'(r_left) : 8'd0;
            r_out.run_enter   <= i_cmd.moved & r_enter;
            r_out.current_out <= r_cc ? 8'(r_cur) : 8'd0;
            r_out.started     <= r_cc;
        end
    end

    always_comb begin
        o_stat.req_type     = r_req.req_type;
        o_stat.from_wild    = r_req.from_is_wildcard;
        o_stat.to_wild      = r_req.to_is_wildcard;
        o_stat.sid_zero     = (sid == '0);
        o_stat.eid_zero     = (eid == '0);
        o_stat.st_full      = (r_st_used >= SUW'(STATE_SLOTS));
        o_stat.ev_full      = (r_ev_used >= EUW'(EVENT_SLOTS));
        o_stat.rule_full    = (r_ru_used >= RUW'(RULE_SLOTS));
        o_stat.scan_done    = r_done;
        o_stat.scan_found   = r_found;
        o_stat.need_move    = !r_rtw && !(r_cc && r_rto == r_cur);
        o_stat.cur_concrete = r_cc;
        o_stat.out_busy     = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: sv/rule_table_state_machine.sv
// top level: programmable rule table state machine
// one transaction at a time: a new request is accepted only in idle, after the last result is registered;
// a trigger scans events, then rules up to twice and states up to twice;
// finishing a transaction waits while a previous result is still held with i_out_ready low
// synchronous active-low reset clears the counts and current state, stores are not cleared
module rule_table_state_machine #(
    parameter int STATE_SLOTS = rtsm_pkg::DEF_STATE_SLOTS,
    parameter int EVENT_SLOTS = rtsm_pkg::DEF_EVENT_SLOTS,
    parameter int RULE_SLOTS  = rtsm_pkg::DEF_RULE_SLOTS,
    parameter int ID_BITS     = rtsm_pkg::DEF_ID_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtsm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rtsm_pkg::t_out o_out_data
);
    import rtsm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rtsm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_stat(stat), .o_cmd(cmd)
    );

    rtsm_dp #(
        .STATE_SLOTS(STATE_SLOTS), .EVENT_SLOTS(EVENT_SLOTS),
        .RULE_SLOTS(RULE_SLOTS), .ID_BITS(ID_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_data(i_in_data), .i_cmd(cmd),
        .o_stat(stat), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );
endmodule
